FILE: rtl/mfps_pkg.sv
package mfps_pkg;

	// Payload widths
	localparam int ELEM_W = 16;
	localparam int SUM_W  = 24;
	localparam int OUT_W  = 23;

	// Configuration port
	localparam int CFG_W    = 8;
	localparam int APB_DW   = 32;
	localparam int ADDR_W   = 3;
	localparam int REG_IDX_W = ADDR_W - 2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_MATRIX_SIDE = '0;

	// Defaults
	localparam int MAX_SIDE_DEF = 128;
	localparam int SIDE_RESET   = 128;

	typedef logic signed [SUM_W-1:0] sum_t;

	// Largest positive partial sum, start value of the running minimum
	localparam sum_t SUM_MAX_POS = {1'b0, {(SUM_W-1){1'b1}}};

endpackage

FILE: rtl/min_falling_path_sum_unit.sv
// Channel      | Direction | Signals                                  | Transaction
// -------------+-----------+------------------------------------------+------------------------
// element in   | input     | in_valid, in_ready, element_value        | one matrix element
// result out   | output    | out_valid, out_ready, min_path_sum       | one matrix minimum
// config APB   | input     | psel, penable, pwrite, paddr, pwdata ... | one register access
//
// One element is taken every cycle while in_ready is high; the result of a matrix leaves the
// cycle after its last element. A chain of MAX_SIDE cells holds the previous row; a new sum
// enters the chain at cell MAX_SIDE - side, so it reaches the tail exactly one row later.
// Reset (arst_n low) clears counters, the running minimum and the output valid flag; the chain
// needs no clearing since the first row never reads it.
// A held result stalls input only while out_ready is low; the output register is one deep.
module min_falling_path_sum_unit #(
	parameter int MAX_SIDE = mfps_pkg::MAX_SIDE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// element channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [mfps_pkg::ELEM_W-1:0] element_value,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [mfps_pkg::OUT_W-1:0]  min_path_sum,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mfps_pkg::ADDR_W-1:0]  paddr,
	input  logic [mfps_pkg::APB_DW-1:0]  pwdata,
	output logic [mfps_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);
	import mfps_pkg::*;

	localparam int CNT_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
	localparam int SIDE_RST = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
	localparam logic [SIDE_W-1:0] SIDE_RST_V = SIDE_W'(SIDE_RST);
	localparam logic [CNT_W-1:0]  INJ_RST_V  = CNT_W'(MAX_SIDE - SIDE_RST);

	logic [CFG_W-1:0]  side_cfg_q;
	logic [SIDE_W-1:0] side_q;
	logic [CNT_W-1:0]  inj_q;
	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  row_q;
	sum_t              left_old_q;
	sum_t              run_min_q;
	logic              out_valid_q;
	logic signed [OUT_W-1:0] out_data_q;

	logic              cfg_wr;
	logic [CFG_W-1:0]  wval;
	logic [SIDE_W-1:0] side_next;
	logic              in_fire;
	logic              last_col;
	logic              last_row;
	sum_t              elem_ext;
	sum_t              here_old;
	sum_t              right_old;
	sum_t              best;
	sum_t              fresh;
	sum_t              new_min;
	sum_t              chain [MAX_SIDE];

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[ADDR_W-1:2] == REG_MATRIX_SIDE);
	assign wval   = pwdata[CFG_W-1:0];

	// Clamp the side to 1..MAX_SIDE
	always_comb begin
		if (wval == '0) begin
			side_next = SIDE_W'(1);
		end else if (32'(wval) > 32'(MAX_SIDE)) begin
			side_next = SIDE_W'(MAX_SIDE);
		end else begin
			side_next = SIDE_W'(wval);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_MATRIX_SIDE) begin
			prdata = APB_DW'(side_cfg_q);
		end
	end

	// Handshake
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign min_path_sum = out_data_q;

	// Position decode
	assign last_col = (32'(col_q) + 32'd1) == 32'(side_q);
	assign last_row = (32'(row_q) + 32'd1) == 32'(side_q);

	// Row of cells holding the previous row's best sums
	for (genvar k = 0; k < MAX_SIDE; k++) begin : g_cell
		sum_t prev_k;
		if (k == 0) begin : g_head
			assign prev_k = fresh;
		end else begin : g_body
			assign prev_k = chain[k-1];
		end
		mfps_cell u_cell (
			.clk   (clk),
			.shift (in_fire),
			.load  (inj_q == CNT_W'(k)),
			.fresh (fresh),
			.prev  (prev_k),
			.held  (chain[k])
		);
	end

	assign here_old = chain[MAX_SIDE-1];
	if (MAX_SIDE > 1) begin : g_right
		assign right_old = chain[MAX_SIDE-2];
	end else begin : g_no_right
		assign right_old = chain[MAX_SIDE-1];
	end

	// Best of up to three neighbors plus the element (the element alone on the first row)
	assign elem_ext = SUM_W'(element_value);
	always_comb begin
		best = here_old;
		if (col_q != '0 && left_old_q < best) begin
			best = left_old_q;
		end
		if (!last_col && right_old < best) begin
			best = right_old;
		end
		fresh = (row_q == '0) ? elem_ext : best + elem_ext;
		new_min = (last_row && fresh < run_min_q) ? fresh : run_min_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_cfg_q <= CFG_W'(SIDE_RESET);
			side_q     <= SIDE_RST_V;
			inj_q      <= INJ_RST_V;
		end else if (cfg_wr) begin
			side_cfg_q <= wval;
			side_q     <= side_next;
			inj_q      <= CNT_W'(32'(MAX_SIDE) - 32'(side_next));
		end
	end

	// Sweep position and running minimum; a register write restarts the matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			left_old_q <= '0;
			run_min_q  <= SUM_MAX_POS;
		end else begin
			if (in_fire) begin
				left_old_q <= here_old;
				run_min_q  <= new_min;
				if (!last_col) begin
					col_q <= col_q + CNT_W'(1);
				end else begin
					col_q <= '0;
					if (!last_row) begin
						row_q <= row_q + CNT_W'(1);
					end else begin
						row_q      <= '0;
						left_old_q <= '0;
						run_min_q  <= SUM_MAX_POS;
					end
				end
			end
			if (cfg_wr) begin
				col_q      <= '0;
				row_q      <= '0;
				left_old_q <= '0;
				run_min_q  <= SUM_MAX_POS;
			end
		end
	end

	// Output register: load on the final element, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && last_col && last_row) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && last_col && last_row) begin
			out_data_q <= new_min[OUT_W-1:0];
		end
	end

endmodule

FILE: rtl/mfps_cell.sv
module mfps_cell (
	input  logic              clk,
	input  logic              shift,
	input  logic              load,
	input  mfps_pkg::sum_t    fresh,
	input  mfps_pkg::sum_t    prev,
	output mfps_pkg::sum_t    held
);
	import mfps_pkg::*;

	sum_t best_q;

	// Take the new sum at the injection point, else pass the neighbor along
	always_ff @(posedge clk) begin
		if (shift) begin
			best_q <= load ? fresh : prev;
		end
	end

	assign held = best_q;

endmodule

FILE: rtl/mfps_checker.sv
module mfps_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic signed [mfps_pkg::OUT_W-1:0]  min_path_sum
);
	import mfps_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(min_path_sum))
		else $error("result changed while stalled");

	// Input flows whenever no result waits
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// A held, untaken result blocks input
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result is stalled");

	// A result appears only after an element transaction
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without an element");

endmodule

bind min_falling_path_sum_unit mfps_checker u_mfps_checker (.*);
